[src/tod_pkg.sv]
// Shared types, constants and the orientation classifier for the tap and
// orientation detector. No dependencies.

package tod_pkg;

	localparam int unsigned AXIS_W       = 16;
	localparam int unsigned THR_W        = 15;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned ORI_W        = 3;
	localparam int unsigned WARM_W       = 7;

	localparam logic [WARM_W-1:0] WARMUP_SAMPLES = 7'd100;

	// divide by 100: floor(x / 100) == (x * DIV_MUL) >> DIV_SHIFT for x < 2**16
	localparam int unsigned       DIV_SHIFT = 23;
	localparam logic [16:0]       DIV_MUL   = 17'd83887;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAY_THR = 1'b1;

	typedef logic [ORI_W-1:0]         ori_t;
	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic [THR_W-1:0]         thr_t;

	localparam ori_t ORI_NONE   = 3'd0;
	localparam ori_t ORI_TOP    = 3'd1;
	localparam ori_t ORI_BOTTOM = 3'd2;
	localparam ori_t ORI_LEFT   = 3'd3;
	localparam ori_t ORI_RIGHT  = 3'd4;
	localparam ori_t ORI_UP     = 3'd5;
	localparam ori_t ORI_DOWN   = 3'd6;

	// priority x, then z, then y
	function automatic ori_t tod_classify(input axis_t x, input axis_t y, input axis_t z,
			input thr_t lay);
		logic signed [AXIS_W:0] hi;
		logic signed [AXIS_W:0] lo;
		logic signed [AXIS_W:0] xe;
		logic signed [AXIS_W:0] ye;
		logic signed [AXIS_W:0] ze;
		ori_t                   ori;
		hi  = $signed({2'b00, lay});
		lo  = -hi;
		xe  = {x[AXIS_W-1], x};
		ye  = {y[AXIS_W-1], y};
		ze  = {z[AXIS_W-1], z};
		priority if (xe > hi) ori = ORI_LEFT;
		else if (xe < lo)     ori = ORI_RIGHT;
		else if (ze > hi)     ori = ORI_BOTTOM;
		else if (ze < lo)     ori = ORI_TOP;
		else if (ye > hi)     ori = ORI_DOWN;
		else if (ye < lo)     ori = ORI_UP;
		else                  ori = ORI_NONE;
		return ori;
	endfunction

endpackage

[src/tod_smooth.sv]
// One axis of the smoothing filter: s <= trunc((99*s + a) / 100).
// Holds the smoothed value; depends on tod_pkg.

module tod_smooth (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tod_pkg::axis_t sample,
	output tod_pkg::axis_t smoothed_next
);
	import tod_pkg::*;

	axis_t                  s_q;
	logic signed [AXIS_W:0] diff;
	logic signed [AXIS_W:0] diff_neg;
	logic [AXIS_W-1:0]      dmag;
	logic [32:0]            prod;
	logic [9:0]             qm;
	logic                   rem_nz;
	logic signed [17:0]     qd;
	logic signed [17:0]     t;
	logic signed [17:0]     t_adj;

	// 99*s + a = 100*s + (a - s)
	assign diff     = {sample[AXIS_W-1], sample} - {s_q[AXIS_W-1], s_q};
	assign diff_neg = -diff;
	assign dmag     = diff[AXIS_W] ? diff_neg[AXIS_W-1:0] : diff[AXIS_W-1:0];
	assign prod     = {17'd0, dmag} * {16'd0, DIV_MUL};
	assign qm       = prod[32:DIV_SHIFT];
	assign rem_nz   = prod[DIV_SHIFT-1:0] >= {6'd0, DIV_MUL};
	assign qd       = diff[AXIS_W] ? -$signed({8'd0, qm}) : $signed({8'd0, qm});
	assign t        = {{2{s_q[AXIS_W-1]}}, s_q} + qd;

	always_comb begin
		t_adj = t;
		if (rem_nz && diff[AXIS_W] && t > 18'sd0) begin
			t_adj = t - 18'sd1;
		end else if (rem_nz && !diff[AXIS_W] && t < 18'sd0) begin
			t_adj = t + 18'sd1;
		end
	end

	assign smoothed_next = t_adj[AXIS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else if (en) begin
			s_q <= smoothed_next;
		end
	end

endmodule

[src/tap_and_orientation_detector.sv]
// Top level of the tap and orientation detector.
// Depends on tod_pkg and tod_smooth.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one accelerometer sample per
//   beat: accel_x, accel_y, accel_z and link_up. Output channel
//   (out_valid/out_stall) carries one result per input beat: tap_seen,
//   side_changed, orientation and fire, in input order.
//   Config channel (cfg_valid/cfg_ready) writes the tap limit (index 0) and
//   the lay limit (index 1); cfg_ready is always high. Write only while idle.
//   Pipeline: two register stages; an accepted beat waits in the input register
//   and moves into the output register once that one is empty or unstalled.
//   Throughput: one beat per cycle unless stalled. The sample is registered, then
//   the tap check, the three smoothing lanes (one 16x17 reciprocal multiply
//   each), classification and warm-up count run into the output register.
//   Reset: thresholds return to 200 and 500, filter state, previous sample,
//   last orientation and warm-up count clear; no beat is pending.
//   Stall: a stalled result holds. One more beat is taken into the input
//   register behind it; then in_stall follows out_stall.

module tap_and_orientation_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tod_pkg::axis_t                   accel_x,
	input  tod_pkg::axis_t                   accel_y,
	input  tod_pkg::axis_t                   accel_z,
	input  logic                             link_up,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             tap_seen,
	output logic                             side_changed,
	output tod_pkg::ori_t                    orientation,
	output logic                             fire,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tod_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tod_pkg::THR_W-1:0]        cfg_data
);
	import tod_pkg::*;

	thr_t              tap_thr_q;
	thr_t              lay_thr_q;

	logic              v_s1;
	axis_t             x_s1;
	axis_t             y_s1;
	axis_t             z_s1;
	logic              link_s1;

	logic              v_s2;
	logic              tap_s2;
	logic              chg_s2;
	ori_t              ori_s2;
	logic              fire_s2;

	axis_t             prev_x_q;
	axis_t             prev_y_q;
	axis_t             prev_z_q;
	ori_t              last_ori_q;
	logic [WARM_W-1:0] warm_q;

	logic              adv2;
	logic              adv1;
	logic              proc;

	axis_t             smn_x;
	axis_t             smn_y;
	axis_t             smn_z;

	ori_t              prev_side;
	ori_t              side;
	logic              sel_ok;
	axis_t             cur_a;
	axis_t             prev_a;
	logic [AXIS_W:0]   abs_cur;
	logic [AXIS_W:0]   abs_prev;
	logic signed [AXIS_W+1:0] growth;
	logic              tap;
	logic              changed;
	logic [WARM_W-1:0] warm_eff;
	logic [WARM_W-1:0] warm_next;

	assign adv2     = !v_s2 || !out_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign proc     = v_s1 && adv2;
	assign cfg_ready = 1'b1;

	tod_smooth u_sm_x (.clk, .arst_n, .en(proc), .sample(x_s1), .smoothed_next(smn_x));
	tod_smooth u_sm_y (.clk, .arst_n, .en(proc), .sample(y_s1), .smoothed_next(smn_y));
	tod_smooth u_sm_z (.clk, .arst_n, .en(proc), .sample(z_s1), .smoothed_next(smn_z));

	assign prev_side = tod_classify(prev_x_q, prev_y_q, prev_z_q, lay_thr_q);

	always_comb begin
		sel_ok = 1'b1;
		cur_a  = x_s1;
		prev_a = prev_x_q;
		unique case (prev_side)
			ORI_TOP, ORI_BOTTOM: begin
				cur_a  = z_s1;
				prev_a = prev_z_q;
			end
			ORI_LEFT, ORI_RIGHT: begin
				cur_a  = x_s1;
				prev_a = prev_x_q;
			end
			ORI_UP, ORI_DOWN: begin
				cur_a  = y_s1;
				prev_a = prev_y_q;
			end
			default: begin
				sel_ok = 1'b0;
			end
		endcase
	end

	assign abs_cur  = cur_a[AXIS_W-1] ? (17'd0 - {1'b1, cur_a}) : {1'b0, cur_a};
	assign abs_prev = prev_a[AXIS_W-1] ? (17'd0 - {1'b1, prev_a}) : {1'b0, prev_a};
	assign growth   = $signed({1'b0, abs_cur}) - $signed({1'b0, abs_prev});
	assign tap      = sel_ok && (growth > $signed({3'b000, tap_thr_q}));

	assign side    = tod_classify(smn_x, smn_y, smn_z, lay_thr_q);
	assign changed = (side != last_ori_q) && (side != ORI_NONE);

	assign warm_eff  = link_s1 ? warm_q : '0;
	assign warm_next = (warm_eff < WARMUP_SAMPLES + 7'd1) ? warm_eff + 7'd1 : warm_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_thr_q  <= 15'd200;
			lay_thr_q  <= 15'd500;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_z_q   <= '0;
			last_ori_q <= ORI_NONE;
			warm_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_TAP_THR: tap_thr_q <= cfg_data;
					REG_LAY_THR: lay_thr_q <= cfg_data;
					default: ;
				endcase
			end
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (proc) begin
				prev_x_q   <= x_s1;
				prev_y_q   <= y_s1;
				prev_z_q   <= z_s1;
				last_ori_q <= side;
				warm_q     <= warm_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			x_s1    <= accel_x;
			y_s1    <= accel_y;
			z_s1    <= accel_z;
			link_s1 <= link_up;
		end
		if (proc) begin
			tap_s2  <= tap;
			chg_s2  <= changed;
			ori_s2  <= side;
			fire_s2 <= (tap || changed) && (warm_eff > WARMUP_SAMPLES);
		end
	end

	assign out_valid    = v_s2;
	assign tap_seen     = tap_s2;
	assign side_changed = chg_s2;
	assign orientation  = ori_s2;
	assign fire         = fire_s2;

endmodule

[src/tod_checker.sv]
// Port-level checks for tap_and_orientation_detector, bound to the top level.
// Depends on tod_pkg.

module tod_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          tap_seen,
	input logic                          side_changed,
	input tod_pkg::ori_t                 orientation,
	input logic                          fire
);
	import tod_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tap_seen) && $stable(side_changed)
			&& $stable(orientation) && $stable(fire))
		else $error("stalled result changed");

	a_fire_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fire |-> tap_seen || side_changed)
		else $error("fire without tap or side change");

	a_side_nonneutral: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side_changed |-> orientation != ORI_NONE)
		else $error("side change to neutral orientation");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1 out_valid)
		else $error("accepted beat did not reach the output");

endmodule

bind tap_and_orientation_detector tod_checker u_tod_checker (.*);

[sim/tod_checker.sv]
// Scoreboard for tap_and_orientation_detector: watches the sample, result and config
// channels, predicts every result beat and compares it field by field.
// Depends on tod_pkg for port types, orientation codes and register indexes.

module tod_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  tod_pkg::axis_t                accel_x,
	input  tod_pkg::axis_t                accel_y,
	input  tod_pkg::axis_t                accel_z,
	input  logic                          link_up,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          tap_seen,
	input  logic                          side_changed,
	input  tod_pkg::ori_t                 orientation,
	input  logic                          fire,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [tod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  tod_pkg::thr_t                 cfg_data,
	output int                            checked_count,
	output int                            fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import tod_pkg::*;

	typedef struct packed {
		logic tap;
		logic changed;
		ori_t ori;
		logic fire;
	} verdict_t;

	verdict_t expected_q[$];

	thr_t tap_thr;
	thr_t lay_thr;
	int   raw_prev[3];
	int   smooth[3];
	ori_t last_ori;
	int   warm;

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// x decides first, then z, then y
	function automatic ori_t side_of(input int x, input int y, input int z);
		int lim;
		lim = int'(lay_thr);
		if (x > lim) return ORI_LEFT;
		if (x < -lim) return ORI_RIGHT;
		if (z > lim) return ORI_BOTTOM;
		if (z < -lim) return ORI_TOP;
		if (y > lim) return ORI_DOWN;
		if (y < -lim) return ORI_UP;
		return ORI_NONE;
	endfunction

	function automatic verdict_t predict_sample(input int ax, input int ay, input int az,
			input logic lk);
		verdict_t v;
		int       cur[3];
		int       sel;
		int       i;
		ori_t     prior;
		ori_t     now;
		cur[0] = ax;
		cur[1] = ay;
		cur[2] = az;
		if (!lk) warm = 0;
		prior = side_of(raw_prev[0], raw_prev[1], raw_prev[2]);
		case (prior)
			ORI_TOP, ORI_BOTTOM: sel = 2;
			ORI_LEFT, ORI_RIGHT: sel = 0;
			ORI_UP, ORI_DOWN:    sel = 1;
			default:             sel = -1;
		endcase
		v.tap = 1'b0;
		if (sel >= 0)
			v.tap = (mag(cur[sel]) - mag(raw_prev[sel])) > int'(tap_thr);
		for (i = 0; i < 3; i++)
			smooth[i] = (99 * smooth[i] + cur[i]) / 100;
		now = side_of(smooth[0], smooth[1], smooth[2]);
		v.changed = (now != last_ori) && (now != ORI_NONE);
		v.ori = now;
		v.fire = (v.tap || v.changed) && (warm > int'(WARMUP_SAMPLES));
		last_ori = now;
		if (warm < int'(WARMUP_SAMPLES) + 1) warm++;
		for (i = 0; i < 3; i++)
			raw_prev[i] = cur[i];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		verdict_t want;
		int       errs;
		int       i;
		if (!arst_n) begin
			tap_thr = 15'd200;
			lay_thr = 15'd500;
			for (i = 0; i < 3; i++) begin
				raw_prev[i] = 0;
				smooth[i] = 0;
			end
			last_ori = ORI_NONE;
			warm = 0;
			expected_q.delete();
			checked_count <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TAP_THR: tap_thr = cfg_data;
					REG_LAY_THR: lay_thr = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_sample(int'(accel_x), int'(accel_y),
					int'(accel_z), link_up));
			if (out_valid && !out_stall) begin
				checked_count <= checked_count + 1;
				if (expected_q.size() == 0) begin
					$error("result beat with no sample pending");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					errs = 0;
					if (tap_seen !== want.tap) begin
						$error("tap_seen: expected %0d, got %0d", want.tap, tap_seen);
						errs++;
					end
					if (side_changed !== want.changed) begin
						$error("side_changed: expected %0d, got %0d", want.changed, side_changed);
						errs++;
					end
					if (orientation !== want.ori) begin
						$error("orientation: expected %0d, got %0d", want.ori, orientation);
						errs++;
					end
					if (fire !== want.fire) begin
						$error("fire: expected %0d, got %0d", want.fire, fire);
						errs++;
					end
					fail_count <= fail_count + errs;
				end
			end
		end
	end

endmodule

[sim/tb_tap_and_orientation_detector.sv]
// Testbench top for tap_and_orientation_detector: clock, reset, sample and config
// stimulus with random idling, and the final verdict.
// Depends on tod_pkg, the detector RTL and tod_scoreboard.

module tb_tap_and_orientation_detector;
	timeunit 1ns;
	timeprecision 1ps;
	import tod_pkg::*;

	localparam int LIMIT = 600000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	axis_t                accel_x = '0;
	axis_t                accel_y = '0;
	axis_t                accel_z = '0;
	logic                 link_up = 1'b0;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	thr_t                 cfg_data = '0;

	logic in_stall;
	logic out_valid;
	logic tap_seen;
	logic side_changed;
	ori_t orientation;
	logic fire;
	logic cfg_ready;

	int   checked_count;
	int   fail_count;
	int   sent = 0;
	int   cycle_cnt = 0;
	int   stall_left = 0;
	logic calm = 1'b0;
	thr_t tap_cfg = 15'd200;
	thr_t lay_cfg = 15'd500;

	tap_and_orientation_detector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.link_up      (link_up),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tap_seen     (tap_seen),
		.side_changed (side_changed),
		.orientation  (orientation),
		.fire         (fire),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	tod_scoreboard u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.link_up       (link_up),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tap_seen      (tap_seen),
		.side_changed  (side_changed),
		.orientation   (orientation),
		.fire          (fire),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.checked_count (checked_count),
		.fail_count    (fail_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int burst_len();
		return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
	endfunction

	function automatic int idle_len();
		if (calm || $urandom_range(0, 99) < 55) return 0;
		return burst_len();
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left <= burst_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [15:0] clip(input int v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	task automatic push_sample(input int x, input int y, input int z, input logic lk);
		int gap;
		in_valid <= 1'b1;
		accel_x <= clip(x);
		accel_y <= clip(y);
		accel_z <= clip(z);
		link_up <= lk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (checked_count != sent) @(posedge clk);
	endtask

	task automatic set_thresholds(input thr_t tap, input thr_t lay);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TAP_THR;
		cfg_data <= tap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_LAY_THR;
		cfg_data <= lay;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tap_cfg = tap;
		lay_cfg = lay;
	endtask

	// device resting on one axis or on none, with jitter, sprinkled with knocks and junk beats
	task automatic run_episode(input int len);
		int dom;
		int sgn;
		int level;
		int noise;
		int s[3];
		int i;
		int k;
		int r;
		dom = $urandom_range(0, 3);
		sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
		if ($urandom_range(0, 3) == 0)
			level = $urandom_range(0, 32767);
		else
			level = int'(lay_cfg) + int'($urandom_range(1, 4000));
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 200);
		for (k = 0; k < len; k++) begin
			for (i = 0; i < 3; i++)
				s[i] = int'($urandom_range(0, 2 * noise)) - noise;
			if (dom < 3) s[dom] += sgn * level;
			r = $urandom_range(0, 99);
			if (r < 6 && dom < 3) begin
				s[dom] += sgn * (int'(tap_cfg) + int'($urandom_range(0, 3000)));
			end else if (r < 9) begin
				for (i = 0; i < 3; i++)
					s[i] = int'($urandom_range(0, 65535)) - 32768;
			end
			push_sample(s[0], s[1], s[2], $urandom_range(0, 99) >= 2);
		end
	endtask

	task automatic run_phase(input thr_t tap, input thr_t lay, input int count,
			input logic quiet);
		int done;
		int len;
		drain();
		set_thresholds(tap, lay);
		calm <= quiet;
		done = 0;
		while (done < count) begin
			len = $urandom_range(20, 150);
			if (len > count - done) len = count - done;
			run_episode(len);
			done += len;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: 200 / 500
		push_sample(0, 0, 0, 1'b1);
		push_sample(32767, 0, 0, 1'b1);
		push_sample(-32768, 0, 0, 1'b1);
		push_sample(0, 0, 0, 1'b1);
		push_sample(0, 0, -32768, 1'b1);
		push_sample(0, 0, 32767, 1'b1);
		push_sample(0, 32767, 0, 1'b0);
		push_sample(0, -32768, 0, 1'b1);
		push_sample(0, 0, 0, 1'b1);
		push_sample(600, 0, 0, 1'b1);
		push_sample(32767, 0, 0, 1'b1);
		push_sample(0, 0, -700, 1'b1);
		push_sample(0, 0, -32768, 1'b1);
		push_sample(0, -600, 0, 1'b1);
		push_sample(0, -2000, 0, 1'b1);
		push_sample(-32768, -32768, -32768, 1'b1);
		push_sample(32767, 32767, 32767, 1'b1);
		push_sample(-1, -1, -1, 1'b0);
		repeat (4) push_sample(32767, 0, 0, 1'b1);

		run_phase(15'd0, 15'd0, 350, 1'b0);
		run_phase(15'h7fff, 15'h7fff, 350, 1'b0);
		run_phase(15'd1000, 15'd4000, 350, 1'b1);
		run_phase(thr_t'($urandom_range(0, 5000)), thr_t'($urandom_range(0, 20000)), 350,
			1'b0);
		run_phase(15'd200, 15'd500, 350, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
src/tod_pkg.sv
src/tod_smooth.sv
src/tap_and_orientation_detector.sv
src/tod_checker.sv
sim/tod_checker.sv
sim/tb_tap_and_orientation_detector.sv
